FILE: design/rmat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmat_pkg;

    // payload field widths
    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 12;
    localparam int PREFIX_W   = 32;
    localparam int CNT_W      = 6;
    localparam int THR_W      = 32;
    localparam int WORD_W     = 64;
    localparam int COIN_LSB   = 32;
    localparam int NODE_W     = 63;

    // configuration register widths
    localparam int SCALE_W    = 6;
    localparam int TSIZE_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE = 2'd0,
        CFG_TSIZE = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_ALIAS = 2'd2,
        ST_MERGE = 2'd3
    } t_state;

endpackage

`default_nettype wire

FILE: design/rmat_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rmat_in_if;
    logic                          valid;
    logic                          ready;
    logic [rmat_pkg::CMD_W-1:0]    command;
    logic [rmat_pkg::SLOT_W-1:0]   entry_index;
    logic [rmat_pkg::PREFIX_W-1:0] entry_row_bits;
    logic [rmat_pkg::PREFIX_W-1:0] entry_col_bits;
    logic [rmat_pkg::CNT_W-1:0]    entry_bit_count;
    logic [rmat_pkg::THR_W-1:0]    entry_threshold;
    logic [rmat_pkg::SLOT_W-1:0]   entry_alias;
    logic [rmat_pkg::WORD_W-1:0]   random_word;

    modport source (
        output valid, command, entry_index, entry_row_bits, entry_col_bits,
               entry_bit_count, entry_threshold, entry_alias, random_word,
        input  ready
    );

    modport sink (
        input  valid, command, entry_index, entry_row_bits, entry_col_bits,
               entry_bit_count, entry_threshold, entry_alias, random_word,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/rmat_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rmat_out_if;
    logic                        valid;
    logic                        ready;
    logic [rmat_pkg::NODE_W-1:0] row_node;
    logic [rmat_pkg::NODE_W-1:0] col_node;
    logic                        last_edge;

    modport source (
        output valid, row_node, col_node, last_edge,
        input  ready
    );

    modport sink (
        input  valid, row_node, col_node, last_edge,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/rmat_alias_edge_sampler.sv
// R-MAT edge sampler over a preloaded alias table.
// Input channel i_in carries one word per handshake: a load word writes one
// table entry, a sample word draws one entry from its random bits, a clear
// word empties the partial edge. Output channel o_out carries one finished
// edge per word, with last_edge set on the final edge of a sample word.
// Configuration (scale, table size) is written through i_cfg_*, by the user
// only while idle; the block does not enforce this. Load and clear words
// are handled in idle. A sample reads its entry, then its alias entry when
// the alias is taken (one synchronous table read per lookup), then merges;
// the single 63-bit shift/merge stage closes one edge per cycle while the
// output register is free. The first edge of a sample reaches o_out through
// the output register, which lets the next word be taken while an edge
// still waits. When the receiver stalls, merging holds and i_in stays not
// ready until the remaining edges of the word are taken.
// Reset (synchronous, active low) restores scale 10 and table size 2^12 and
// empties the partial edge; table entries are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module rmat_alias_edge_sampler #(
    parameter int TABLE_ENTRIES  = 4096,
    parameter int ENTRY_MAX_BITS = 32,
    parameter int NODE_BITS      = 63
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rmat_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [rmat_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rmat_in_if.sink                                i_in,
    rmat_out_if.source                             o_out
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int EMB    = ENTRY_MAX_BITS;
    localparam int CNT_W  = rmat_pkg::CNT_W;
    localparam int SC_W   = rmat_pkg::SCALE_W;
    localparam int TS_W   = rmat_pkg::TSIZE_W;
    localparam int THR_W  = rmat_pkg::THR_W;
    localparam int OUT_W  = rmat_pkg::NODE_W;
    localparam int ACC_W  = (NODE_BITS > EMB) ? NODE_BITS : EMB;

    typedef struct packed {
        logic [EMB-1:0]   row;
        logic [EMB-1:0]   col;
        logic [CNT_W-1:0] cnt;
        logic [THR_W-1:0] thr;
        logic [IDX_W-1:0] alt_idx;
    } t_entry;

    // configuration registers
    logic [SC_W-1:0] r_scale;
    logic [TS_W-1:0] r_tsize;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SC_W'(10);
            r_tsize <= TS_W'(12);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == rmat_pkg::CFG_SCALE) begin
                r_scale <= i_cfg_data[SC_W-1:0];
            end
            if (i_cfg_idx == rmat_pkg::CFG_TSIZE) begin
                r_tsize <= i_cfg_data[TS_W-1:0];
            end
        end
    end

    // effective scale, clamped to one and to the node width
    logic [SC_W-1:0] w_sc;
    always_comb begin
        if (r_scale == '0) begin
            w_sc = SC_W'(1);
        end else if (int'(r_scale) > NODE_BITS) begin
            w_sc = SC_W'(NODE_BITS);
        end else begin
            w_sc = r_scale;
        end
    end

    // state and datapath registers
    rmat_pkg::t_state   r_state, n_state;
    logic [THR_W-1:0]     r_coin, n_coin;
    logic [EMB-1:0]       r_pend_row, n_pend_row;
    logic [EMB-1:0]       r_pend_col, n_pend_col;
    logic [CNT_W-1:0]     r_pcnt, n_pcnt;
    logic [NODE_BITS-1:0] r_acc_row, n_acc_row;
    logic [NODE_BITS-1:0] r_acc_col, n_acc_col;
    logic [CNT_W-1:0]     r_done, n_done;
    logic                 r_out_valid, n_out_valid;
    logic [NODE_BITS-1:0] r_out_row, n_out_row;
    logic [NODE_BITS-1:0] r_out_col, n_out_col;
    logic                 r_out_last, n_out_last;

    // table memory, one entry word per slot
    t_entry           mem [TABLE_ENTRIES];
    t_entry           r_rd_q;
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_wa;
    t_entry           w_mem_wd;
    logic             w_mem_re;
    logic [IDX_W-1:0] w_mem_ra;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_mem_re) begin
            r_rd_q <= mem[w_mem_ra];
        end
    end

    // input handshake
    logic w_in_acc;
    assign i_in.ready = (r_state == rmat_pkg::ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;

    // load word: saturate count, drop prefix bits above it
    logic [CNT_W-1:0] w_ld_cnt;
    logic [EMB-1:0]   w_ld_mask;
    always_comb begin
        if (int'(i_in.entry_bit_count) > EMB) begin
            w_ld_cnt = CNT_W'(EMB);
        end else begin
            w_ld_cnt = i_in.entry_bit_count;
        end
        for (int i = 0; i < EMB; i++) begin
            w_ld_mask[i] = (i < int'(w_ld_cnt));
        end
        w_mem_wd.row     = i_in.entry_row_bits[EMB-1:0] & w_ld_mask;
        w_mem_wd.col     = i_in.entry_col_bits[EMB-1:0] & w_ld_mask;
        w_mem_wd.cnt     = w_ld_cnt;
        w_mem_wd.thr     = i_in.entry_threshold;
        w_mem_wd.alt_idx = i_in.entry_alias[IDX_W-1:0];
        w_mem_wa         = i_in.entry_index[IDX_W-1:0];
    end

    // sample index masked to the table size in use
    logic [IDX_W-1:0] w_idx_mask;
    logic [IDX_W-1:0] w_smp_idx;
    always_comb begin
        for (int i = 0; i < IDX_W; i++) begin
            w_idx_mask[i] = (i < int'(r_tsize));
        end
        w_smp_idx = i_in.random_word[IDX_W-1:0] & w_idx_mask;
    end

    // merge stage: close one edge or fold the rest into the partial edge
    logic [CNT_W:0]       w_sum;
    logic                 w_hit;
    logic [CNT_W-1:0]     w_need;
    logic [CNT_W-1:0]     w_rest;
    logic [EMB-1:0]       w_keep;
    logic                 w_last;
    logic [ACC_W-1:0]     w_edge_row_x, w_edge_col_x;
    logic [ACC_W-1:0]     w_fold_row_x, w_fold_col_x;
    logic [ACC_W-1:0]     w_left_row_x, w_left_col_x;
    always_comb begin
        w_sum  = {1'b0, r_done} + {1'b0, r_pcnt};
        w_hit  = (w_sum >= {1'b0, w_sc});
        w_need = w_sc - r_done;
        w_rest = r_pcnt - w_need;
        for (int i = 0; i < EMB; i++) begin
            w_keep[i] = (i < int'(w_rest));
        end
        w_last       = (w_rest < w_sc);
        w_edge_row_x = (ACC_W'(r_acc_row) << w_need) | (ACC_W'(r_pend_row) >> w_rest);
        w_edge_col_x = (ACC_W'(r_acc_col) << w_need) | (ACC_W'(r_pend_col) >> w_rest);
        w_fold_row_x = (ACC_W'(r_acc_row) << r_pcnt) | ACC_W'(r_pend_row);
        w_fold_col_x = (ACC_W'(r_acc_col) << r_pcnt) | ACC_W'(r_pend_col);
        w_left_row_x = ACC_W'(r_pend_row & w_keep);
        w_left_col_x = ACC_W'(r_pend_col & w_keep);
    end

    logic w_out_free;
    assign w_out_free = !r_out_valid || o_out.ready;

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_coin      = r_coin;
        n_pend_row  = r_pend_row;
        n_pend_col  = r_pend_col;
        n_pcnt      = r_pcnt;
        n_acc_row   = r_acc_row;
        n_acc_col   = r_acc_col;
        n_done      = r_done;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_ra    = w_smp_idx;

        case (r_state)
            rmat_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    case (rmat_pkg::t_cmd'(i_in.command))
                        rmat_pkg::CMD_LOAD: begin
                            w_mem_we = 1'b1;
                        end
                        rmat_pkg::CMD_SAMPLE: begin
                            w_mem_re = 1'b1;
                            n_coin   = i_in.random_word[rmat_pkg::COIN_LSB +: THR_W];
                            n_state  = rmat_pkg::ST_READ;
                        end
                        rmat_pkg::CMD_CLEAR: begin
                            n_acc_row = '0;
                            n_acc_col = '0;
                            n_done    = '0;
                            n_pcnt    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // first lookup back: take the alias or keep this entry
            rmat_pkg::ST_READ: begin
                if (r_coin <= r_rd_q.thr) begin
                    w_mem_re = 1'b1;
                    w_mem_ra = r_rd_q.alt_idx;
                    n_state  = rmat_pkg::ST_ALIAS;
                end else begin
                    n_pend_row = r_rd_q.row;
                    n_pend_col = r_rd_q.col;
                    n_pcnt     = r_rd_q.cnt;
                    n_state    = rmat_pkg::ST_MERGE;
                    if (r_done >= w_sc) begin
                        n_acc_row = '0;
                        n_acc_col = '0;
                        n_done    = '0;
                    end
                end
            end

            rmat_pkg::ST_ALIAS: begin
                n_pend_row = r_rd_q.row;
                n_pend_col = r_rd_q.col;
                n_pcnt     = r_rd_q.cnt;
                n_state    = rmat_pkg::ST_MERGE;
                if (r_done >= w_sc) begin
                    n_acc_row = '0;
                    n_acc_col = '0;
                    n_done    = '0;
                end
            end

            rmat_pkg::ST_MERGE: begin
                if (!w_hit) begin
                    n_acc_row = w_fold_row_x[NODE_BITS-1:0];
                    n_acc_col = w_fold_col_x[NODE_BITS-1:0];
                    n_done    = w_sum[CNT_W-1:0];
                    n_pcnt    = '0;
                    n_state   = rmat_pkg::ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = w_edge_row_x[NODE_BITS-1:0];
                    n_out_col   = w_edge_col_x[NODE_BITS-1:0];
                    n_out_last  = w_last;
                    if (w_last) begin
                        n_acc_row = w_left_row_x[NODE_BITS-1:0];
                        n_acc_col = w_left_col_x[NODE_BITS-1:0];
                        n_done    = w_rest;
                        n_pcnt    = '0;
                        n_state   = rmat_pkg::ST_IDLE;
                    end else begin
                        n_acc_row  = '0;
                        n_acc_col  = '0;
                        n_done     = '0;
                        n_pend_row = r_pend_row & w_keep;
                        n_pend_col = r_pend_col & w_keep;
                        n_pcnt     = w_rest;
                    end
                end
            end

            default: begin
                n_state = rmat_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmat_pkg::ST_IDLE;
            r_pcnt      <= '0;
            r_acc_row   <= '0;
            r_acc_col   <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pcnt      <= n_pcnt;
            r_acc_row   <= n_acc_row;
            r_acc_col   <= n_acc_col;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_coin     <= n_coin;
        r_pend_row <= n_pend_row;
        r_pend_col <= n_pend_col;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_last <= n_out_last;
    end

    // output word
    assign o_out.valid     = r_out_valid;
    assign o_out.row_node  = OUT_W'(r_out_row);
    assign o_out.col_node  = OUT_W'(r_out_col);
    assign o_out.last_edge = r_out_last;

`ifndef SYNTHESIS
    // a new edge only comes out of the merge stage
    a_edge_from_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == rmat_pkg::ST_MERGE))
        else $error("edge raised outside merge");

    // a stalled receiver freezes the pending bits
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmat_pkg::ST_MERGE && w_hit && r_out_valid && !o_out.ready)
        |=> (r_state == rmat_pkg::ST_MERGE) && $stable(r_pcnt))
        else $error("merge advanced under stall");

    // pending bits are fully merged outside the merge stage
    a_pend_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rmat_pkg::ST_MERGE) |-> (r_pcnt == '0))
        else $error("pending bits left outside merge");
`endif

endmodule

`default_nettype wire
